FILE: sv/psl_pkg.sv
// Shared types and codes for the priority sorted list unit.
// No dependencies; compile first.
package psl_pkg;

  // Default sizing
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int ID_BITS_DEF   = 8;

  // Fixed field widths on the channels
  localparam int REQ_W  = 2;
  localparam int PRIO_W = 8;
  localparam int ID_W   = 8;
  localparam int POS_W  = 4;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_INS     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_ID  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_POS = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

  // Result status
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_ID   = 2'd2;
  localparam logic [ST_W-1:0] ST_POS  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   elem_id;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  index_out;
    logic [ID_W-1:0]   id_out;
    logic [PRIO_W-1:0] priority_out;
    logic [CNT_W-1:0]  count;
  } rsp_t;

endpackage

FILE: sv/psl_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Depends on psl_pkg for the default payload type.
interface psl_stream_if
  import psl_pkg::*;
#(
  parameter type payload_t = req_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/psl_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on nothing beyond its parameters.
module psl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/psl_ctrl.sv
// Sequencer for the sorted list: scans, shifts and updates the entry store
// through one shared compare path. Depends on psl_pkg and drives psl_ram.
module psl_ctrl
  import psl_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int MW = ID_BITS + PRIO_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  req_t          req,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output rsp_t          res_out,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [MW-1:0] mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [MW-1:0] mem_rdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // walk entries, compare id / priority
  localparam logic [2:0] S_SHUP = 3'd2;  // open a gap for insert
  localparam logic [2:0] S_CAP  = 3'd3;  // capture entry read by position
  localparam logic [2:0] S_SHDN = 3'd4;  // close a gap after delete
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]           state;
  logic [REQ_W-1:0]     op;
  logic [PRIO_BITS-1:0] rq_prio;
  logic [ID_BITS-1:0]   rq_id;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        ptr;
  logic                 pend;
  logic [AW-1:0]        pidx;
  logic                 dup;
  logic                 hit;
  logic [AW-1:0]        hidx;
  logic                 wvld;
  logic [AW-1:0]        wa;
  rsp_t                 res;

  logic [ID_BITS-1:0]   rd_id;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 id_eq;
  logic                 prio_gt;

  assign rd_id   = mem_rdata[PRIO_BITS +: ID_BITS];
  assign rd_prio = mem_rdata[PRIO_BITS-1:0];
  assign id_eq   = (rd_id == rq_id);
  assign prio_gt = (rd_prio > rq_prio);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res_out       = res;
    res_out.count = CNT_W'(cnt);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wa;
    mem_wdata = mem_rdata;
    mem_raddr = AW'(ptr);
    unique case (state)
      S_IDLE: begin
        mem_raddr = AW'(req.position);
      end
      S_SHUP: begin
        mem_we    = wvld;
        mem_raddr = AW'(ptr - 1'b1);
        if (ptr <= CW'(hidx) && !wvld) begin
          mem_we    = 1'b1;
          mem_waddr = hidx;
          mem_wdata = {rq_id, rq_prio};
        end
      end
      S_SHDN: begin
        mem_we = wvld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      wvld  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= req.req_type;
            rq_prio <= PRIO_BITS'(req.priority_req);
            rq_id   <= ID_BITS'(req.elem_id);
            pend    <= 1'b0;
            dup     <= 1'b0;
            hit     <= 1'b0;
            wvld    <= 1'b0;
            ptr     <= '0;
            if (req.req_type == REQ_INS || req.req_type == REQ_DEL_ID) begin
              state <= S_SCAN;
            end else if (32'(req.position) >= 32'(cnt) || 32'(req.position) >= DEPTH) begin
              res   <= '{status: ST_POS, default: '0};
              state <= S_DONE;
            end else begin
              hidx  <= AW'(req.position);
              state <= S_CAP;
            end
          end
        end

        S_SCAN: begin
          if (ptr < cnt) begin
            ptr  <= ptr + 1'b1;
            pidx <= AW'(ptr);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (op == REQ_INS) begin
              if (id_eq) begin
                dup <= 1'b1;
              end
              // first entry with a larger value is where the new one goes
              if (!hit && prio_gt) begin
                hit  <= 1'b1;
                hidx <= pidx;
              end
            end else if (id_eq && !hit) begin
              hit              <= 1'b1;
              hidx             <= pidx;
              res.id_out       <= ID_W'(rd_id);
              res.priority_out <= PRIO_W'(rd_prio);
            end
          end
          if (ptr >= cnt && !pend) begin
            if (op == REQ_INS) begin
              if (dup) begin
                res   <= '{status: ST_ID, default: '0};
                state <= S_DONE;
              end else if (cnt == CW'(DEPTH)) begin
                res   <= '{status: ST_FULL, default: '0};
                state <= S_DONE;
              end else begin
                if (!hit) begin
                  hidx <= AW'(cnt);
                end
                wvld  <= 1'b0;
                state <= S_SHUP;
              end
            end else if (!hit) begin
              res   <= '{status: ST_ID, default: '0};
              state <= S_DONE;
            end else begin
              ptr   <= CW'(hidx) + 1'b1;
              wvld  <= 1'b0;
              state <= S_SHDN;
            end
          end
        end

        S_SHUP: begin
          if (ptr > CW'(hidx)) begin
            wa   <= AW'(ptr);
            wvld <= 1'b1;
            ptr  <= ptr - 1'b1;
          end else begin
            wvld <= 1'b0;
            if (!wvld) begin
              // new entry written this cycle
              cnt              <= cnt + 1'b1;
              res.status       <= ST_OK;
              res.index_out    <= IDX_W'(hidx);
              res.id_out       <= ID_W'(rq_id);
              res.priority_out <= PRIO_W'(rq_prio);
              state            <= S_DONE;
            end
          end
        end

        S_CAP: begin
          res.status       <= ST_OK;
          res.index_out    <= IDX_W'(hidx);
          res.id_out       <= ID_W'(rd_id);
          res.priority_out <= PRIO_W'(rd_prio);
          if (op == REQ_READ) begin
            state <= S_DONE;
          end else begin
            ptr   <= CW'(hidx) + 1'b1;
            wvld  <= 1'b0;
            state <= S_SHDN;
          end
        end

        S_SHDN: begin
          if (ptr < cnt) begin
            wa   <= AW'(ptr - 1'b1);
            wvld <= 1'b1;
            ptr  <= ptr + 1'b1;
          end else begin
            wvld <= 1'b0;
            if (!wvld) begin
              cnt           <= cnt - 1'b1;
              res.status    <= ST_OK;
              res.index_out <= IDX_W'(hidx);
              state         <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: sv/priority_sorted_list_unit.sv
// Top level of the priority sorted list: request/response channels,
// output register, entry store and sequencer. Depends on psl_pkg,
// psl_stream_if, psl_ram and psl_ctrl.
//
//   channel | dir | payload | transaction when
//   --------+-----+---------+------------------------
//   req     | in  | req_t   | req.valid && req.ready
//   rsp     | out | rsp_t   | rsp.valid && rsp.ready
//
// Insert scans the stored entries, shifts the entries above the insert
// point up, writes the new entry and loads the result; delete by id
// scans, then shifts the entries above the hit down; delete by position
// captures the entry and shifts down; read captures the entry. The
// single-port-pair entry store allows one read and one write per cycle.
// Reset empties the list at once. req is taken only while the sequencer
// is idle; a result waiting in the output register holds the next one in its final state.
module priority_sorted_list_unit
  import psl_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  psl_stream_if.sink   req,
  psl_stream_if.source rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int MW = ID_BITS + PRIO_BITS;

  logic          idle;
  logic          res_valid;
  logic          res_ready;
  rsp_t          res;
  logic          ovld;
  rsp_t          odata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  assign req.ready = idle;
  assign res_ready = !ovld || rsp.ready;
  assign rsp.valid = ovld;
  assign rsp.data  = odata;

  psl_ctrl #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .ID_BITS   (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && idle),
    .req       (req.data),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  psl_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (res_valid && res_ready) begin
      ovld <= 1'b1;
    end else if (rsp.ready) begin
      ovld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      odata <= res;
    end
  end
endmodule
